FILE: rtl/core/cswm_pkg.sv
// Package for the clock / stopwatch mode controller: codes, widths and the result type.
`default_nettype none

package cswm_pkg;

    localparam int KIND_W    = 1;
    localparam int KEY_W     = 8;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int ACTION_W  = 3;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 32;
    localparam int TICK_W    = 8;
    localparam int MS_W      = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // result actions
    localparam logic [ACTION_W-1:0] ACT_TIME  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WATCH = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RTC   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SAVE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MODE  = 3'd4;

    // modes
    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SETTING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WATCH   = 2'd2;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 1'b0;
    localparam logic [KIND_W-1:0] KIND_KEY  = 1'b1;

    // keys that act
    localparam logic [KEY_W-1:0] KEY_ONE   = 8'd1;
    localparam logic [KEY_W-1:0] KEY_TWO   = 8'd2;
    localparam logic [KEY_W-1:0] KEY_THREE = 8'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_DIVISOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK      = 2'd2;

    localparam logic [TICK_W-1:0] TPS_RESET     = 8'd100;
    localparam logic [TICK_W-1:0] DIVISOR_RESET = 8'd10;
    localparam logic [MS_W-1:0]   MS_RESET      = 10'd10;

    localparam logic [TICK_W-1:0]   WATCH_WRAP  = 8'd100;
    localparam logic [HOUR_W:0]     HOURS_DAY   = 6'd24;
    localparam logic [MINUTE_W:0]   MINUTES_HR  = 7'd60;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MODE_W-1:0]   mode;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [COUNT_W-1:0]  elapsed_ms;
        logic                running;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/clock_stopwatch_mode_controller.sv
// Top level of the clock / stopwatch mode controller.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall | kind key_num key_down rtc_hour/minute/second
//  out     | source    | out_valid/out_stall | action mode hour minute second elapsed_ms running
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index cfg_data
//
//  One request per cycle while in_stall is low: all state is updated in the accept cycle
//  and the result (if any) is registered in the output register, or in the skid register
//  when the output is stalled. A one-entry skid register behind the output register keeps
//  input open while a result waits; in_stall rises when the skid register is full or a
//  remainder pass runs. A nonzero refresh_divisor write starts a bit-serial remainder pass
//  (tick_counter mod divisor); input stalls and cfg_ready drops until the pass ends.
//  Reset (rst_n, async, active low) sets mode normal, stopwatch stopped and
//  cleared, counters and cached time zero, registers to their defaults.
`default_nettype none

module clock_stopwatch_mode_controller
    import cswm_pkg::*;
(
    input  wire  logic                 clk,
    input  wire  logic                 rst_n,

    input  wire  logic                 in_valid,
    output logic                       in_stall,
    input  wire  logic [KIND_W-1:0]    kind,
    input  wire  logic [KEY_W-1:0]     key_num,
    input  wire  logic                 key_down,
    input  wire  logic [HOUR_W-1:0]    rtc_hour,
    input  wire  logic [MINUTE_W-1:0]  rtc_minute,
    input  wire  logic [SECOND_W-1:0]  rtc_second,

    output logic                       out_valid,
    input  wire  logic                 out_stall,
    output logic [ACTION_W-1:0]        action,
    output logic [MODE_W-1:0]          mode,
    output logic [HOUR_W-1:0]          hour,
    output logic [MINUTE_W-1:0]        minute,
    output logic [SECOND_W-1:0]        second,
    output logic [COUNT_W-1:0]         elapsed_ms,
    output logic                       running,

    input  wire  logic                 cfg_valid,
    output logic                       cfg_ready,
    input  wire  logic [CFG_IDX_W-1:0] cfg_index,
    input  wire  logic [CFG_DAT_W-1:0] cfg_data
);

    // configuration
    logic [TICK_W-1:0] tps_reg;
    logic [TICK_W-1:0] divisor_reg;
    logic [MS_W-1:0]   ms_reg;

    // controller state
    logic [MODE_W-1:0]   mode_reg,    mode_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic                run_reg,     run_next;
    logic [TICK_W-1:0]   tick_reg,    tick_next;
    logic [HOUR_W-1:0]   hour_reg,    hour_next;
    logic [MINUTE_W-1:0] minute_reg,  minute_next;
    logic [SECOND_W-1:0] second_reg,  second_next;

    // residue_reg tracks tick_reg mod divisor_reg, so the refresh test is a compare
    logic [TICK_W-1:0] residue_reg, residue_next;
    logic [TICK_W-1:0] residue_inc;

    // remainder pass after a divisor write
    logic       busy_reg;
    logic [2:0] bit_reg;
    logic [TICK_W:0]   div_trial;
    logic [TICK_W-1:0] div_rem;

    // output register and skid entry
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    logic    in_accept;
    logic    cfg_accept;
    logic    out_ready;
    logic    emit;
    logic [ACTION_W-1:0] emit_action;
    result_t emit_data;

    logic [TICK_W-1:0]   tick_inc;
    logic [HOUR_W:0]     hour_inc;
    logic [MINUTE_W:0]   minute_inc;
    logic                key_acts;

    assign in_stall   = skid_valid_reg || busy_reg;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = !busy_reg;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_ready  = !out_valid_reg || !out_stall;

    assign tick_inc    = tick_reg + 8'd1;
    assign residue_inc = ((residue_reg + 8'd1) == divisor_reg) ? '0 : residue_reg + 8'd1;
    assign hour_inc    = {1'b0, hour_reg} + 6'd1;
    assign minute_inc  = {1'b0, minute_reg} + 7'd1;
    assign key_acts    = key_down && (key_num == KEY_ONE || key_num == KEY_TWO ||
                                      key_num == KEY_THREE);

    // one restoring-division step per cycle, MSB of tick_reg first
    assign div_trial = {residue_reg, tick_reg[bit_reg]};
    assign div_rem   = (div_trial >= {1'b0, divisor_reg})
                     ? TICK_W'(div_trial - {1'b0, divisor_reg})
                     : div_trial[TICK_W-1:0];

    always_comb
    begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        tick_next    = tick_reg;
        residue_next = residue_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        emit         = 1'b0;
        emit_action  = ACT_TIME;

        if (in_accept)
        begin
            if (kind == KIND_TICK)
            begin
                unique case (mode_reg) inside
                    MODE_NORMAL, MODE_SETTING:
                    begin
                        if (tick_inc >= tps_reg)
                        begin
                            tick_next    = '0;
                            residue_next = '0;
                            hour_next    = rtc_hour;
                            minute_next  = rtc_minute;
                            second_next  = rtc_second;
                            emit         = 1'b1;
                            emit_action  = ACT_TIME;
                        end
                        else
                        begin
                            tick_next    = tick_inc;
                            residue_next = residue_inc;
                        end
                    end
                    MODE_WATCH:
                    begin
                        if (run_reg)
                        begin
                            count_next = count_reg + {{(COUNT_W-MS_W){1'b0}}, ms_reg};
                            if (divisor_reg == '0 || residue_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_action = ACT_WATCH;
                            end
                        end
                        if (tick_inc >= WATCH_WRAP)
                        begin
                            tick_next    = '0;
                            residue_next = '0;
                        end
                        else
                        begin
                            tick_next    = tick_inc;
                            residue_next = residue_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (key_acts)
            begin
                unique case (mode_reg)
                    MODE_NORMAL:
                    begin
                        if (key_num == KEY_ONE)
                        begin
                            mode_next   = MODE_SETTING;
                            emit        = 1'b1;
                            emit_action = ACT_MODE;
                        end
                        else if (key_num == KEY_TWO)
                        begin
                            mode_next   = MODE_WATCH;
                            emit        = 1'b1;
                            emit_action = ACT_MODE;
                        end
                    end
                    MODE_SETTING:
                    begin
                        emit = 1'b1;
                        if (key_num == KEY_ONE)
                        begin
                            mode_next   = MODE_NORMAL;
                            emit_action = ACT_MODE;
                        end
                        else if (key_num == KEY_TWO)
                        begin
                            // cached hour may be out of range; one subtract covers it
                            hour_next   = (hour_inc >= HOURS_DAY)
                                        ? HOUR_W'(hour_inc - HOURS_DAY)
                                        : hour_inc[HOUR_W-1:0];
                            emit_action = ACT_RTC;
                        end
                        else
                        begin
                            minute_next = (minute_inc >= MINUTES_HR)
                                        ? MINUTE_W'(minute_inc - MINUTES_HR)
                                        : minute_inc[MINUTE_W-1:0];
                            second_next = '0;
                            emit_action = ACT_RTC;
                        end
                    end
                    MODE_WATCH:
                    begin
                        if (key_num == KEY_ONE)
                        begin
                            mode_next   = MODE_NORMAL;
                            emit        = 1'b1;
                            emit_action = ACT_MODE;
                        end
                        else if (key_num == KEY_TWO)
                        begin
                            run_next = !run_reg;
                        end
                        else if (run_reg)
                        begin
                            emit        = 1'b1;
                            emit_action = ACT_SAVE;
                        end
                        else
                        begin
                            count_next  = '0;
                            emit        = 1'b1;
                            emit_action = ACT_WATCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // results carry the state after the step
    always_comb
    begin
        emit_data.action     = emit_action;
        emit_data.mode       = mode_next;
        emit_data.hour       = hour_next;
        emit_data.minute     = minute_next;
        emit_data.second     = second_next;
        emit_data.elapsed_ms = count_next;
        emit_data.running    = run_next;
    end

    // configuration and the remainder pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg     <= TPS_RESET;
            divisor_reg <= DIVISOR_RESET;
            ms_reg      <= MS_RESET;
            busy_reg    <= 1'b0;
            bit_reg     <= '0;
        end
        else if (busy_reg)
        begin
            bit_reg <= bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_SECOND: tps_reg <= cfg_data[TICK_W-1:0];
                CFG_REFRESH_DIVISOR:
                begin
                    divisor_reg <= cfg_data[TICK_W-1:0];
                    // divisor zero refreshes every tick; residue unused then
                    busy_reg    <= (cfg_data[TICK_W-1:0] != '0);
                    bit_reg     <= 3'(TICK_W - 1);
                end
                CFG_MS_PER_TICK:      ms_reg <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            count_reg   <= '0;
            run_reg     <= 1'b0;
            tick_reg    <= '0;
            residue_reg <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            run_reg    <= run_next;
            tick_reg   <= tick_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            if (busy_reg)
            begin
                residue_reg <= div_rem;
            end
            else if (cfg_accept && cfg_index == CFG_REFRESH_DIVISOR)
            begin
                residue_reg <= '0;
            end
            else
            begin
                residue_reg <= residue_next;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (emit)
            begin
                out_data_reg <= emit_data;
            end
        end
        else if (emit)
        begin
            skid_data_reg <= emit_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = out_data_reg.action;
    assign mode       = out_data_reg.mode;
    assign hour       = out_data_reg.hour;
    assign minute     = out_data_reg.minute;
    assign second     = out_data_reg.second;
    assign elapsed_ms = out_data_reg.elapsed_ms;
    assign running    = out_data_reg.running;

    // checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (in_stall && !cfg_ready))
        else $error("request accepted during remainder pass");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && divisor_reg != '0) |-> (residue_reg < divisor_reg))
        else $error("tick residue out of range");

    a_tick_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg != 8'hFF)
        else $error("tick counter reached all ones");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && emit) |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

`default_nettype wire
